// ===== rtl/sfe_pkg.sv =====
package sfe_pkg;

    // Default build values for the top-level parameters.
    localparam int MOTORS_DEF    = 4;
    localparam int SLOTS_DEF     = 4;
    localparam int MAX_STEPS_DEF = 16;

    // Driver ids are stored at the full width of the id field.
    localparam int DRV_W     = 5;
    localparam int OUT_SLOTS = 4;

    typedef logic [1:0] t_op;
    typedef logic [1:0] t_kind;
    typedef logic [1:0] t_status;
    typedef logic [1:0] t_dir;

    // Request operations.
    localparam t_op OP_RESET = 2'd0;
    localparam t_op OP_BIND  = 2'd1;
    localparam t_op OP_EMIT  = 2'd2;

    // Result kinds.
    localparam t_kind K_STATUS = 2'd0;
    localparam t_kind K_DIR    = 2'd1;
    localparam t_kind K_EDGE   = 2'd2;

    // Bind status codes.
    localparam t_status ST_OK    = 2'd0;
    localparam t_status ST_RANGE = 2'd1;
    localparam t_status ST_FULL  = 2'd2;

    // Direction mark for a motor whose direction pins are not known.
    localparam t_dir DIR_UNKNOWN = 2'd2;

endpackage

// ===== rtl/sfe_row_mem.sv =====
module sfe_row_mem
    import sfe_pkg::*;
#(
    parameter int DEPTH = MOTORS_DEF,
    parameter int WIDTH = SLOTS_DEF * (DRV_W + 1),
    localparam int AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             i_clk,
    input  logic             i_rd_en,
    input  logic [AW-1:0]    i_rd_addr,
    output logic [WIDTH-1:0] o_rd_data,
    input  logic             i_wr_en,
    input  logic [AW-1:0]    i_wr_addr,
    input  logic [WIDTH-1:0] i_wr_data
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] r_rd_data;

    // One write port; read data is registered and holds until the next read.
    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            r_rd_data <= mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;

endmodule

// ===== rtl/step_pulse_fanout_emitter_core.sv =====
// Step pulse fanout emitter.
//
// The request channel (i_valid, o_stall) carries one operation: reset bindings,
// bind a driver id to a motor, or emit a signed number of steps for a motor.
// The result channel (o_valid, i_stall) returns status answers, direction
// results and step-edge results; o_last marks the final result of a request.
// Bindings live in a row memory with one row per motor and a registered read.
// A reset request gives no result. A bind reads the motor's row when it is
// accepted, then issues its status result and, on success, writes the row back.
// An emit reads the row when it is accepted, then issues up to one
// direction result and up to MAX_STEPS edge results. The single output
// register issues one result per cycle while the receiver does not stall;
// one request is in work at a time.
// When the receiver stalls, the output register holds its result and the
// sequencer waits; o_stall stays high until the request is finished.
// Reset clears every binding count and marks every direction unknown; the
// binding memory needs no clearing pass.
module step_pulse_fanout_emitter_core
    import sfe_pkg::*;
#(
    parameter int MOTORS          = MOTORS_DEF,
    parameter int SLOTS_PER_MOTOR = SLOTS_DEF,
    parameter int MAX_STEPS       = MAX_STEPS_DEF
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    // Request channel.
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [1:0]        i_operation,
    input  logic [2:0]        i_motor,
    input  logic [4:0]        i_stepper_id,
    input  logic              i_invert,
    input  logic signed [5:0] i_step_count,
    // Result channel.
    output logic              o_valid,
    input  logic              i_stall,
    output logic [1:0]        o_kind,
    output logic [1:0]        o_motor_out,
    output logic [3:0]        o_slot_mask,
    output logic [4:0]        o_driver_a,
    output logic [4:0]        o_driver_b,
    output logic [4:0]        o_driver_c,
    output logic [4:0]        o_driver_d,
    output logic [3:0]        o_dir_levels,
    output logic [1:0]        o_status,
    output logic              o_last
);

    localparam int MW = (MOTORS > 1) ? $clog2(MOTORS) : 1;
    localparam int CW = $clog2(SLOTS_PER_MOTOR + 1);
    localparam int SW = $clog2(MAX_STEPS + 1);
    localparam int EW = DRV_W + 1;
    localparam int RW = SLOTS_PER_MOTOR * EW;

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_BIND = 2'd1;
    localparam logic [1:0] S_DIR  = 2'd2;
    localparam logic [1:0] S_EDGE = 2'd3;

    // Control state.
    logic [1:0]    r_state, n_state;
    logic [CW-1:0] r_count [MOTORS];
    t_dir          r_dir [MOTORS];
    logic [SW-1:0] r_left, n_left;

    // Request context held while the request is worked on.
    logic [2:0]       r_motor;
    logic [CW-1:0]    r_cnt;
    logic [DRV_W-1:0] r_id;
    logic             r_inv;
    logic             r_rev;
    t_status          r_status;

    // Output register.
    logic                   r_out_valid;
    t_kind                  r_out_kind;
    logic [1:0]             r_out_motor;
    logic [OUT_SLOTS-1:0]   r_out_mask;
    logic [DRV_W-1:0]       r_out_drv [OUT_SLOTS];
    logic [OUT_SLOTS-1:0]   r_out_levels;
    t_status                r_out_status;
    logic                   r_out_last;

    // Memory port signals.
    logic          mem_rd_en;
    logic [RW-1:0] mem_rd_data;
    logic          mem_wr_en;
    logic [RW-1:0] mem_wr_data;

    // Request decode.
    logic          accept;
    logic          in_range;
    logic [MW-1:0] midx;
    logic [CW-1:0] cur_cnt;
    t_dir          cur_dir;
    logic [5:0]    raw_u;
    logic [5:0]    mag6;
    logic [SW-1:0] mag_sat;
    logic          raw_rev;
    logic          emit_go;
    t_status       bind_status;

    // Slot view of the row read for the current motor.
    logic [OUT_SLOTS-1:0] slot_mask;
    logic [DRV_W-1:0]     slot_drv [OUT_SLOTS];
    logic [OUT_SLOTS-1:0] slot_levels;

    // Result offered to the output register this cycle.
    logic                 out_free;
    logic                 e_valid;
    t_kind                e_kind;
    logic [1:0]           e_motor;
    logic                 e_slots;
    logic                 e_levels;
    t_status              e_status;
    logic                 e_last;
    logic                 bind_commit;

    assign o_stall  = (r_state != S_IDLE);
    assign accept   = i_valid && (r_state == S_IDLE);
    assign out_free = !r_out_valid || !i_stall;

    assign in_range = ({1'b0, i_motor} < 4'(MOTORS));
    assign midx     = i_motor[MW-1:0];
    assign cur_cnt  = r_count[midx];
    assign cur_dir  = r_dir[midx];

    // Magnitude of the step count, saturated to the step limit.
    assign raw_u   = i_step_count;
    assign raw_rev = raw_u[5];
    assign mag6    = raw_rev ? 6'(~raw_u + 6'd1) : raw_u;
    assign mag_sat = ({1'b0, mag6} > 7'(MAX_STEPS)) ? SW'(MAX_STEPS) : SW'(mag6);

    assign emit_go = in_range && (cur_cnt != '0) && (raw_u != '0);

    always_comb begin
        if (!in_range) begin
            bind_status = ST_RANGE;
        end else if (cur_cnt >= CW'(SLOTS_PER_MOTOR)) begin
            bind_status = ST_FULL;
        end else begin
            bind_status = ST_OK;
        end
    end

    // Bound slots of the row, with the direction level of each.
    for (genvar j = 0; j < OUT_SLOTS; j++) begin : g_slot
        if (j < SLOTS_PER_MOTOR) begin : g_used
            assign slot_mask[j]   = (r_cnt > CW'(j));
            assign slot_drv[j]    = slot_mask[j] ? mem_rd_data[j*EW +: DRV_W] : '0;
            assign slot_levels[j] = slot_mask[j] & (~r_rev ^ mem_rd_data[j*EW + DRV_W]);
        end else begin : g_none
            assign slot_mask[j]   = 1'b0;
            assign slot_drv[j]    = '0;
            assign slot_levels[j] = 1'b0;
        end
    end

    // Row written back by a bind: the next free slot takes the new entry.
    for (genvar s = 0; s < SLOTS_PER_MOTOR; s++) begin : g_wr
        assign mem_wr_data[s*EW +: EW] = (r_cnt == CW'(s)) ? {r_inv, r_id}
                                                          : mem_rd_data[s*EW +: EW];
    end

    // Sequencer: one result per cycle into the output register while it is free.
    always_comb begin
        n_state     = r_state;
        n_left      = r_left;
        mem_rd_en   = 1'b0;
        e_valid     = 1'b0;
        e_kind      = K_STATUS;
        e_motor     = r_motor[1:0];
        e_slots     = 1'b0;
        e_levels    = 1'b0;
        e_status    = ST_OK;
        e_last      = 1'b0;
        bind_commit = 1'b0;
        case (r_state)
            S_IDLE: begin
                if (accept) begin
                    case (i_operation)
                        OP_BIND: begin
                            mem_rd_en = 1'b1;
                            n_state   = S_BIND;
                        end
                        OP_EMIT: begin
                            if (emit_go) begin
                                mem_rd_en = 1'b1;
                                n_left    = mag_sat;
                                n_state   = (cur_dir != {1'b0, raw_rev}) ? S_DIR : S_EDGE;
                            end
                        end
                        default: begin
                            n_state = S_IDLE;
                        end
                    endcase
                end
            end
            S_BIND: begin
                if (out_free) begin
                    e_valid     = 1'b1;
                    e_kind      = K_STATUS;
                    e_motor     = (r_status == ST_RANGE) ? 2'd0 : r_motor[1:0];
                    e_status    = r_status;
                    e_last      = 1'b1;
                    bind_commit = (r_status == ST_OK);
                    n_state     = S_IDLE;
                end
            end
            S_DIR: begin
                if (out_free) begin
                    e_valid  = 1'b1;
                    e_kind   = K_DIR;
                    e_slots  = 1'b1;
                    e_levels = 1'b1;
                    n_state  = S_EDGE;
                end
            end
            S_EDGE: begin
                if (out_free) begin
                    e_valid = 1'b1;
                    e_kind  = K_EDGE;
                    e_slots = 1'b1;
                    e_last  = (r_left == SW'(1));
                    n_left  = r_left - SW'(1);
                    if (r_left == SW'(1)) begin
                        n_state = S_IDLE;
                    end
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    assign mem_wr_en = bind_commit;

    sfe_row_mem #(
        .DEPTH (MOTORS),
        .WIDTH (RW)
    ) u_row_mem (
        .i_clk     (i_clk),
        .i_rd_en   (mem_rd_en),
        .i_rd_addr (midx),
        .o_rd_data (mem_rd_data),
        .i_wr_en   (mem_wr_en),
        .i_wr_addr (r_motor[MW-1:0]),
        .i_wr_data (mem_wr_data)
    );

    // Control state, counts and direction marks.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_left      <= '0;
            r_out_valid <= 1'b0;
            for (int m = 0; m < MOTORS; m++) begin
                r_count[m] <= '0;
                r_dir[m]   <= DIR_UNKNOWN;
            end
        end else begin
            r_state <= n_state;
            r_left  <= n_left;
            if (out_free) begin
                r_out_valid <= e_valid;
            end
            if (accept && (i_operation == OP_RESET)) begin
                for (int m = 0; m < MOTORS; m++) begin
                    r_count[m] <= '0;
                    r_dir[m]   <= DIR_UNKNOWN;
                end
            end
            if (accept && (i_operation == OP_EMIT) && emit_go) begin
                r_dir[midx] <= {1'b0, raw_rev};
            end
            if (bind_commit) begin
                r_count[r_motor[MW-1:0]] <= CW'(r_cnt + CW'(1));
                r_dir[r_motor[MW-1:0]]   <= DIR_UNKNOWN;
            end
        end
    end

    // Request context.
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_motor  <= i_motor;
            r_cnt    <= cur_cnt;
            r_id     <= i_stepper_id;
            r_inv    <= i_invert;
            r_rev    <= raw_rev;
            r_status <= bind_status;
        end
    end

    // Output payload.
    always_ff @(posedge i_clk) begin
        if (out_free && e_valid) begin
            r_out_kind   <= e_kind;
            r_out_motor  <= e_motor;
            r_out_mask   <= e_slots ? slot_mask : '0;
            r_out_levels <= e_levels ? slot_levels : '0;
            r_out_status <= e_status;
            r_out_last   <= e_last;
            for (int j = 0; j < OUT_SLOTS; j++) begin
                r_out_drv[j] <= e_slots ? slot_drv[j] : '0;
            end
        end
    end

    assign o_valid      = r_out_valid;
    assign o_kind       = r_out_kind;
    assign o_motor_out  = r_out_motor;
    assign o_slot_mask  = r_out_mask;
    assign o_driver_a   = r_out_drv[0];
    assign o_driver_b   = r_out_drv[1];
    assign o_driver_c   = r_out_drv[2];
    assign o_driver_d   = r_out_drv[3];
    assign o_dir_levels = r_out_levels;
    assign o_status     = r_out_status;
    assign o_last       = r_out_last;

    // A status answer is always the only result of its request.
    a_status_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_STATUS)) |-> o_last)
        else $error("status result without last");

    // A direction result is always followed by at least one edge.
    a_dir_not_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_kind == K_DIR)) |-> !o_last)
        else $error("direction result marked last");

    // The edge sequencer never runs with no steps left.
    a_edge_left: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_EDGE) |-> (r_left != '0))
        else $error("edge state with zero steps left");

    // A reset request clears the first motor's bindings.
    a_reset_clears: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && (i_operation == OP_RESET)) |=> (r_count[0] == '0))
        else $error("reset request left a binding count");

endmodule

// ===== dv/step_pulse_fanout_emitter_core_test.sv =====
import sfe_pkg::*;

// Result as it leaves the block; drv[j] is the driver id shown for slot j.
typedef struct packed {
    t_kind              kind;
    logic [1:0]         motor;
    logic [3:0]         mask;
    logic [3:0][4:0]    drv;
    logic [3:0]         levels;
    t_status            status;
    logic               last;
} t_step_result;

// Tracks the binding table and direction marks and keeps the results that
// the accepted requests still owe.
class fanout_scoreboard;
    logic [4:0]   bound_id  [MOTORS_DEF][SLOTS_DEF];
    logic         bound_inv [MOTORS_DEF][SLOTS_DEF];
    int unsigned  bound_cnt [MOTORS_DEF];
    t_dir         dir_mark  [MOTORS_DEF];
    t_step_result awaited_outputs[$];
    int unsigned  errors;

    function new();
        errors = 0;
        clear_bindings();
    endfunction

    function void clear_bindings();
        for (int m = 0; m < MOTORS_DEF; m++) begin
            bound_cnt[m] = 0;
            dir_mark[m]  = DIR_UNKNOWN;
        end
    endfunction

    function int unsigned pending();
        return awaited_outputs.size();
    endfunction

    // Work out every result that one accepted request causes.
    function void accept_request(t_op op, logic [2:0] motor, logic [4:0] id,
                                 logic inv, logic signed [5:0] steps);
        t_step_result r;
        int           sc;
        int unsigned  mag;
        int unsigned  slot;
        logic         rev;
        r  = '0;
        sc = int'(steps);
        case (op)
            OP_RESET: begin
                clear_bindings();
            end
            OP_BIND: begin
                r.kind = K_STATUS;
                r.last = 1'b1;
                if (motor >= MOTORS_DEF) begin
                    r.status = ST_RANGE;
                end else if (bound_cnt[motor] >= SLOTS_DEF) begin
                    r.status = ST_FULL;
                    r.motor  = motor[1:0];
                end else begin
                    slot = bound_cnt[motor];
                    bound_id[motor][slot]  = id;
                    bound_inv[motor][slot] = inv;
                    bound_cnt[motor]       = slot + 1;
                    dir_mark[motor]        = DIR_UNKNOWN;
                    r.status = ST_OK;
                    r.motor  = motor[1:0];
                end
                awaited_outputs.push_back(r);
            end
            OP_EMIT: begin
                if (motor >= MOTORS_DEF || bound_cnt[motor] == 0 || sc == 0)
                    return;
                rev = (sc < 0);
                mag = rev ? -sc : sc;
                if (mag > MAX_STEPS_DEF)
                    mag = MAX_STEPS_DEF;
                r.motor = motor[1:0];
                for (int j = 0; j < bound_cnt[motor] && j < OUT_SLOTS; j++) begin
                    r.mask[j]   = 1'b1;
                    r.drv[j]    = bound_id[motor][j];
                    r.levels[j] = ~rev ^ bound_inv[motor][j];
                end
                // A direction result goes first whenever the wanted direction
                // differs from the mark, including an unknown mark.
                if (dir_mark[motor] != t_dir'({1'b0, rev})) begin
                    r.kind = K_DIR;
                    awaited_outputs.push_back(r);
                    dir_mark[motor] = t_dir'({1'b0, rev});
                end
                r.kind   = K_EDGE;
                r.levels = '0;
                for (int unsigned i = 0; i < mag; i++) begin
                    r.last = (i + 1 == mag);
                    awaited_outputs.push_back(r);
                end
            end
            default: begin
                // The fourth operation code does nothing.
            end
        endcase
    endfunction

    function void compare(string field, int unsigned want, int unsigned seen);
        if (want != seen) begin
            $error("%s mismatch: expected %0d, actual %0d", field, want, seen);
            errors++;
        end
    endfunction

    // Compare one delivered result against the oldest one owed.
    function void check_result(t_step_result got);
        t_step_result want;
        if (awaited_outputs.size() == 0) begin
            $error("result with nothing outstanding: kind %0d motor %0d",
                   got.kind, got.motor);
            errors++;
            return;
        end
        want = awaited_outputs.pop_front();
        compare("kind", 32'(want.kind), 32'(got.kind));
        compare("motor_out", 32'(want.motor), 32'(got.motor));
        compare("slot_mask", 32'(want.mask), 32'(got.mask));
        compare("driver_a", 32'(want.drv[0]), 32'(got.drv[0]));
        compare("driver_b", 32'(want.drv[1]), 32'(got.drv[1]));
        compare("driver_c", 32'(want.drv[2]), 32'(got.drv[2]));
        compare("driver_d", 32'(want.drv[3]), 32'(got.drv[3]));
        compare("dir_levels", 32'(want.levels), 32'(got.levels));
        compare("status", 32'(want.status), 32'(got.status));
        compare("last", 32'(want.last), 32'(got.last));
    endfunction
endclass

module step_pulse_fanout_emitter_core_test;

    localparam t_op OP_IGNORED     = 2'd3;
    localparam int  MAX_GAP        = 17;
    localparam int  HOLD_CYCLES    = 300;
    localparam int  QUIET_LIMIT    = 2000;
    localparam int  DRAIN_CYCLES   = 40;
    localparam int  RANDOM_ITEMS   = 200;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [1:0]        i_operation;
    logic [2:0]        i_motor;
    logic [4:0]        i_stepper_id;
    logic              i_invert;
    logic signed [5:0] i_step_count;
    logic              o_valid;
    logic              i_stall;
    logic [1:0]        o_kind;
    logic [1:0]        o_motor_out;
    logic [3:0]        o_slot_mask;
    logic [4:0]        o_driver_a;
    logic [4:0]        o_driver_b;
    logic [4:0]        o_driver_c;
    logic [4:0]        o_driver_d;
    logic [3:0]        o_dir_levels;
    logic [1:0]        o_status;
    logic              o_last;

    fanout_scoreboard sb;
    t_step_result     seen_result;
    int               quiet_cycles = 0;
    int               tx_burst     = 0;
    bit               tx_calm      = 1'b0;
    bit               hold_req     = 1'b0;

    step_pulse_fanout_emitter_core i_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_operation  (i_operation),
        .i_motor      (i_motor),
        .i_stepper_id (i_stepper_id),
        .i_invert     (i_invert),
        .i_step_count (i_step_count),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_kind       (o_kind),
        .o_motor_out  (o_motor_out),
        .o_slot_mask  (o_slot_mask),
        .o_driver_a   (o_driver_a),
        .o_driver_b   (o_driver_b),
        .o_driver_c   (o_driver_c),
        .o_driver_d   (o_driver_d),
        .o_dir_levels (o_dir_levels),
        .o_status     (o_status),
        .o_last       (o_last)
    );

    // Clock with a period of 10.
    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    // Watch both channels at every rising edge.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (i_valid && !o_stall)
                sb.accept_request(i_operation, i_motor, i_stepper_id, i_invert,
                                  i_step_count);
            if (o_valid && !i_stall) begin
                seen_result.kind   = o_kind;
                seen_result.motor  = o_motor_out;
                seen_result.mask   = o_slot_mask;
                seen_result.drv[0] = o_driver_a;
                seen_result.drv[1] = o_driver_b;
                seen_result.drv[2] = o_driver_c;
                seen_result.drv[3] = o_driver_d;
                seen_result.levels = o_dir_levels;
                seen_result.status = o_status;
                seen_result.last   = o_last;
                sb.check_result(seen_result);
            end
            if ((i_valid && !o_stall) || (o_valid && !i_stall))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
    end

    // Give up when neither channel moves for too long.
    initial begin
        while (quiet_cycles < QUIET_LIMIT)
            @(posedge i_clk);
        $display("TB_ERROR");
        $finish;
    end

    // Offer one request after a drawn gap and hold it until it is taken.
    task automatic send_request(t_op op, logic [2:0] motor, logic [4:0] id,
                                logic inv, logic signed [5:0] steps);
        int gap;
        if (tx_burst > 0) begin
            gap = 0;
            tx_burst--;
        end else begin
            gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
        end
        if (gap > 0) begin
            @(negedge i_clk);
            i_valid <= 1'b0;
            repeat (gap - 1) @(negedge i_clk);
        end
        @(negedge i_clk);
        i_valid      <= 1'b1;
        i_operation  <= op;
        i_motor      <= motor;
        i_stepper_id <= id;
        i_invert     <= inv;
        i_step_count <= steps;
        @(posedge i_clk);
        while (!(i_valid && !o_stall))
            @(posedge i_clk);
    endtask

    // Result side: a drawn stall before each result, calm stretches, and one
    // long hold-off when the stimulus asks for it.
    initial begin : result_sink
        int wait_cycles;
        int taken;
        bit rx_calm;
        taken   = 0;
        rx_calm = 1'b0;
        @(posedge i_rst_n);
        forever begin
            if (taken % 16 == 0)
                rx_calm = ($urandom_range(0, 2) == 0);
            if (hold_req) begin
                hold_req    = 1'b0;
                wait_cycles = HOLD_CYCLES;
            end else begin
                wait_cycles = rx_calm ? 0 : $urandom_range(0, MAX_GAP);
            end
            if (wait_cycles > 0) begin
                @(negedge i_clk);
                i_stall <= 1'b1;
                repeat (wait_cycles - 1) @(negedge i_clk);
            end
            @(negedge i_clk);
            i_stall <= 1'b0;
            @(posedge i_clk);
            while (!(o_valid && !i_stall))
                @(posedge i_clk);
            taken++;
        end
    end

    initial begin : stimulus
        int   counted;
        int   r;
        int   k;
        int   mv;
        t_op  op;
        logic [2:0]        m;
        logic [4:0]        id;
        logic              inv;
        logic signed [5:0] steps;

        sb           = new();
        i_rst_n      = 1'b0;
        i_valid      = 1'b0;
        i_stall      = 1'b0;
        i_operation  = OP_RESET;
        i_motor      = '0;
        i_stepper_id = '0;
        i_invert     = 1'b0;
        i_step_count = '0;
        repeat (6) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty table, filling a motor, range and full answers,
        // direction changes, saturation, ignored codes and the table reset.
        send_request(OP_EMIT, 3'd0, 5'd3, 1'b0, 6'sd5);
        send_request(OP_BIND, 3'd0, 5'd0, 1'b0, 6'sd0);
        send_request(OP_BIND, 3'd0, 5'd31, 1'b1, 6'sd0);
        send_request(OP_BIND, 3'd0, 5'd21, 1'b0, -6'sd1);
        send_request(OP_BIND, 3'd0, 5'd10, 1'b1, 6'sd31);
        send_request(OP_BIND, 3'd0, 5'd7, 1'b0, 6'sd0);
        send_request(OP_BIND, 3'd4, 5'd9, 1'b0, 6'sd0);
        send_request(OP_BIND, 3'd7, 5'd31, 1'b1, -6'sd32);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, 6'sd1);
        send_request(OP_EMIT, 3'd0, 5'd31, 1'b1, 6'sd3);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, -6'sd1);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, -6'sd16);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b1, -6'sd32);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, 6'sd31);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, 6'sd0);
        send_request(OP_EMIT, 3'd5, 5'd0, 1'b0, 6'sd4);
        send_request(OP_IGNORED, 3'd0, 5'd12, 1'b1, 6'sd2);
        send_request(OP_BIND, 3'd3, 5'd5, 1'b1, 6'sd0);
        send_request(OP_EMIT, 3'd3, 5'd0, 1'b0, 6'sd16);
        send_request(OP_BIND, 3'd3, 5'd26, 1'b0, 6'sd0);
        send_request(OP_EMIT, 3'd3, 5'd0, 1'b0, 6'sd17);
        send_request(OP_RESET, 3'd7, 5'd31, 1'b1, -6'sd1);
        send_request(OP_EMIT, 3'd0, 5'd0, 1'b0, 6'sd4);
        send_request(OP_BIND, 3'd1, 5'd1, 1'b0, 6'sd0);
        send_request(OP_EMIT, 3'd1, 5'd0, 1'b0, -6'sd2);

        // Random: mostly binds and emits on valid motors, with occasional
        // table resets, ignored codes and out-of-range motors.
        counted = 0;
        while (counted < RANDOM_ITEMS) begin
            if (counted % 16 == 0)
                tx_calm = ($urandom_range(0, 2) == 0);
            if (counted == 70) begin
                // Long receiver hold-off while requests keep coming.
                hold_req = 1'b1;
                tx_burst = 12;
            end
            r = $urandom_range(0, 99);
            if (r < 4)
                op = OP_RESET;
            else if (r < 7)
                op = OP_IGNORED;
            else if (r < 40)
                op = OP_BIND;
            else
                op = OP_EMIT;
            mv  = ($urandom_range(0, 9) < 8) ? $urandom_range(0, 3) : $urandom_range(4, 7);
            m   = mv[2:0];
            id  = 5'($urandom);
            inv = 1'($urandom);
            r   = $urandom_range(0, 99);
            if (r < 55) begin
                k = $urandom_range(0, 8);
                k = k - 4;
            end else if (r < 85) begin
                k = $urandom_range(0, 63);
                k = k - 32;
            end else begin
                case ($urandom_range(0, 3))
                    0: k = 16;
                    1: k = -16;
                    2: k = 31;
                    default: k = -32;
                endcase
            end
            steps = k[5:0];
            send_request(op, m, id, inv, steps);
            if (op != OP_IGNORED)
                counted++;
        end

        @(negedge i_clk);
        i_valid <= 1'b0;
        while (sb.pending() != 0)
            @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (sb.errors == 0)
            $display("TB_OK");
        else
            $display("TB_ERROR");
        $finish;
    end

endmodule

// ===== sim.f =====
rtl/sfe_pkg.sv
rtl/sfe_row_mem.sv
rtl/step_pulse_fanout_emitter_core.sv
dv/step_pulse_fanout_emitter_core_test.sv
